// ===== rtl/core/cscl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cscl_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int GAIN_WORDS  = 12;
    localparam int GAIN_BITS   = 32;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
    localparam int QUO_BITS    = 10;
    localparam int REM_BITS    = 16;
    localparam int LANES       = 3;
    localparam int ROWS        = 3;
    localparam int REG_BITS    = 12;
    localparam int THR_BITS    = 16;
    localparam int PCT_BITS    = 7;
    localparam int PNUM_BITS   = REG_BITS + PCT_BITS;
    localparam int AMB_BITS    = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int CNT_BITS    = 4;
    localparam int POS_BITS    = 6;
    localparam int ADDR_BITS   = 3;
    localparam int APB_BITS    = 32;

    localparam int IN_RAW_BITS   = 8 + 4 * SAMPLE_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_RAW_BITS  = 3 * 8 + PCT_BITS + 2;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam int GAIN_BYTES = GAIN_WORDS * 4;
    localparam int THRESH_END = GAIN_BYTES + 4;
    localparam int STREAM_END = THRESH_END + 2;

    localparam logic [REM_BITS-1:0]  LEVEL_DIVISOR = REM_BITS'(38000);
    localparam logic [QUO_BITS-1:0]  RED_SAT_QUO   = QUO_BITS'(282);
    localparam logic [QUO_BITS-1:0]  LEVEL_SAT_QUO = QUO_BITS'(256);
    localparam logic [12:0]          RED_RECIP     = 13'd5958;
    localparam int                   RED_SHIFT     = 16;
    localparam logic [7:0]           LEVEL_MAX     = 8'd255;
    localparam logic [REG_BITS-1:0]  FLOOR_RESET   = REG_BITS'(50);
    localparam logic [REG_BITS-1:0]  CEIL_RESET    = REG_BITS'(750);
    localparam logic [PCT_BITS-1:0]  PCT_SCALE     = PCT_BITS'(100);

    localparam logic [IN_USER_BITS-1:0] KIND_MEASURE = IN_USER_BITS'(1);
    localparam logic ADDR_FLOOR_SEL = 1'b0;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [GAIN_BITS-1:0]   gain_t;
    typedef logic [PROD_BITS-1:0]   prod_t;

endpackage

`default_nettype wire

// ===== rtl/core/color_sensor_calibrated_levels_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Calibrated color levels for a four-lamp color sensor. Load words (tuser bit 0 low) carry
// the calibration stream one byte each and are taken in the idle state; tuser bit 1 restarts
// the stream at byte zero. A measure word keeps the block busy from acceptance until it has
// passed the multiply, check, divide and finish states: the three color channels run side by
// side through a bit-serial shift-add multiplier (one sample bit per cycle) and a restoring
// divider by 38000 (one quotient bit per cycle), while the ambient percentage comes from its
// own restoring divider in the divide state. A finished result waits in the output register,
// so a measure word may be accepted while the previous result is still unread.
module color_sensor_calibrated_levels_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // cal_byte, red_sample, green_sample, blue_sample, ambient_sample
    input  logic [cscl_pkg::IN_DATA_BITS-1:0]      s_tdata,
    // kind, restart
    input  logic [cscl_pkg::IN_USER_BITS-1:0]      s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // red_level, green_level, blue_level, ambient_percent, gain_row, zero fill
    output logic [cscl_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cscl_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [cscl_pkg::APB_BITS-1:0]          pwdata,
    output logic [cscl_pkg::APB_BITS-1:0]          prdata,
    output logic                                   pready
);
    import cscl_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [REG_BITS-1:0]  floor_reg;
    logic [REG_BITS-1:0]  ceil_reg;
    gain_t                gain_reg [LANES][ROWS];
    logic [THR_BITS-1:0]  thr_reg [2];
    logic [POS_BITS-1:0]  pos_reg;

    logic [2:0]           state_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    sample_t              diff_reg [LANES];
    logic [LANES-1:0]     neg_reg;
    logic [LANES-1:0]     ovf_reg;
    gain_t                gsel_reg [LANES];
    prod_t                prod_reg [LANES];
    logic [REM_BITS-1:0]  rem_reg [LANES];
    logic [QUO_BITS-1:0]  quo_reg [LANES];
    logic [1:0]           row_reg;

    logic [PNUM_BITS-1:0] pnum_reg;
    logic [REG_BITS-1:0]  prem_reg;
    logic [REG_BITS-1:0]  pden_reg;
    logic [PCT_BITS-1:0]  pquo_reg;
    logic                 pzero_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;

    logic                 accept;
    logic                 cfg_write;
    logic                 is_measure;
    sample_t              smp [LANES];
    sample_t              amb;
    logic [1:0]           row_sel;
    logic [POS_BITS-1:0]  pos_eff;
    logic [AMB_BITS-1:0]  amb_ext;
    logic [REG_BITS-1:0]  clamped;
    logic [REG_BITS-1:0]  pct_diff;
    logic [PNUM_BITS-1:0] pct_num;
    logic                 out_free;

    logic [REM_BITS:0]    trial [LANES];
    logic [REG_BITS:0]    ptrial;
    logic [7:0]           level [LANES];
    logic [QUO_BITS+3:0]  red_x;
    logic [QUO_BITS+16:0] red_prod;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_measure = ((s_tuser & KIND_MEASURE) != '0);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = APB_BITS'((paddr[2] == ADDR_FLOOR_SEL) ? floor_reg : ceil_reg);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            smp[i] = s_tdata[8 + i * SAMPLE_BITS +: SAMPLE_BITS];
        end
        amb = s_tdata[8 + 3 * SAMPLE_BITS +: SAMPLE_BITS];

        if (THR_BITS'(amb) < thr_reg[1])
            row_sel = 2'd2;
        else if (THR_BITS'(amb) < thr_reg[0])
            row_sel = 2'd1;
        else
            row_sel = 2'd0;

        pos_eff = s_tuser[1] ? '0 : pos_reg;

        amb_ext = AMB_BITS'(amb);
        if (amb_ext > AMB_BITS'(ceil_reg))
            clamped = ceil_reg;
        else if (amb_ext < AMB_BITS'(floor_reg))
            clamped = floor_reg;
        else
            clamped = REG_BITS'(amb_ext);
        pct_diff = clamped - floor_reg;
        pct_num  = PNUM_BITS'(pct_diff) * PNUM_BITS'(PCT_SCALE);

        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {rem_reg[i], prod_reg[i][QUO_BITS-1]};
        end
        ptrial = {prem_reg, pnum_reg[PCT_BITS-1]};

        red_x    = (QUO_BITS + 4)'(quo_reg[0]) * (QUO_BITS + 4)'(10);
        red_prod = (QUO_BITS + 17)'(red_x) * (QUO_BITS + 17)'(RED_RECIP);

        for (int i = 0; i < LANES; i++)
        begin
            level[i] = quo_reg[i][7:0];
            if (i == 0)
            begin
                level[i] = red_prod[RED_SHIFT +: 8];
                if (quo_reg[i] >= RED_SAT_QUO)
                    level[i] = LEVEL_MAX;
            end
            else if (quo_reg[i] >= LEVEL_SAT_QUO)
            begin
                level[i] = LEVEL_MAX;
            end
            if (ovf_reg[i])
                level[i] = LEVEL_MAX;
            if (neg_reg[i])
                level[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
            ceil_reg  <= CEIL_RESET;
            thr_reg[0] <= '0;
            thr_reg[1] <= '0;
            pos_reg   <= '0;
            for (int l = 0; l < LANES; l++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    gain_reg[l][r] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == ADDR_FLOOR_SEL)
                    floor_reg <= pwdata[REG_BITS-1:0];
                else
                    ceil_reg <= pwdata[REG_BITS-1:0];
            end
            if (accept && !is_measure)
            begin
                if (pos_eff < POS_BITS'(STREAM_END))
                    pos_reg <= pos_eff + 1'b1;
                else
                    pos_reg <= pos_eff;
                if (pos_eff < POS_BITS'(GAIN_BYTES))
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        for (int r = 0; r < ROWS; r++)
                        begin
                            for (int b = 0; b < 4; b++)
                            begin
                                if (pos_eff[3:2] == 2'(l) && pos_eff[5:4] == 2'(r)
                                    && pos_eff[1:0] == 2'(b))
                                    gain_reg[l][r][8 * b +: 8] <= s_tdata[7:0];
                            end
                        end
                    end
                end
                else if (pos_eff < POS_BITS'(THRESH_END))
                begin
                    for (int t = 0; t < 2; t++)
                    begin
                        for (int b = 0; b < 2; b++)
                        begin
                            if (pos_eff[1] == 1'(t) && pos_eff[0] == 1'(b))
                                thr_reg[t][8 * b +: 8] <= s_tdata[7:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && is_measure)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(SAMPLE_BITS - 1))
                        state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(QUO_BITS - 1))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_measure)
                begin
                    row_reg <= row_sel;
                    for (int i = 0; i < LANES; i++)
                    begin
                        neg_reg[i]  <= (smp[i] < amb);
                        diff_reg[i] <= smp[i] - amb;
                        gsel_reg[i] <= gain_reg[i][row_sel];
                        prod_reg[i] <= '0;
                    end
                    pzero_reg <= (ceil_reg <= floor_reg);
                    pden_reg  <= ceil_reg - floor_reg;
                    pnum_reg  <= pct_num;
                    prem_reg  <= pct_num[PNUM_BITS-1:PCT_BITS];
                    pquo_reg  <= '0;
                end
            end
            ST_MUL:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    prod_reg[i] <= {prod_reg[i][PROD_BITS-2:0], 1'b0}
                                   + (diff_reg[i][SAMPLE_BITS-1] ? PROD_BITS'(gsel_reg[i])
                                                                 : '0);
                    diff_reg[i] <= {diff_reg[i][SAMPLE_BITS-2:0], 1'b0};
                end
            end
            ST_CHK:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    ovf_reg[i] <= (prod_reg[i][PROD_BITS-1:QUO_BITS]
                                   >= (PROD_BITS - QUO_BITS)'(LEVEL_DIVISOR));
                    rem_reg[i] <= prod_reg[i][QUO_BITS +: REM_BITS];
                    quo_reg[i] <= '0;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (trial[i] >= (REM_BITS + 1)'(LEVEL_DIVISOR))
                    begin
                        rem_reg[i] <= REM_BITS'(trial[i] - (REM_BITS + 1)'(LEVEL_DIVISOR));
                        quo_reg[i] <= {quo_reg[i][QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= trial[i][REM_BITS-1:0];
                        quo_reg[i] <= {quo_reg[i][QUO_BITS-2:0], 1'b0};
                    end
                    prod_reg[i] <= {prod_reg[i][PROD_BITS-2:0], 1'b0};
                end
                if (cnt_reg < CNT_BITS'(PCT_BITS))
                begin
                    if (ptrial >= (REG_BITS + 1)'(pden_reg))
                    begin
                        prem_reg <= REG_BITS'(ptrial - (REG_BITS + 1)'(pden_reg));
                        pquo_reg <= {pquo_reg[PCT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        prem_reg <= ptrial[REG_BITS-1:0];
                        pquo_reg <= {pquo_reg[PCT_BITS-2:0], 1'b0};
                    end
                    pnum_reg <= {pnum_reg[PNUM_BITS-2:0], 1'b0};
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg <= OUT_DATA_BITS'({row_reg,
                                                    pzero_reg ? PCT_BITS'(0) : pquo_reg,
                                                    level[2], level[1], level[0]});
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
